>>> rtl/segment_layout_extractor_macros.svh
// Assertion macros used by sle_dp, the datapath of the segment layout extractor.
`ifndef SEGMENT_LAYOUT_EXTRACTOR_MACROS_SVH
`define SEGMENT_LAYOUT_EXTRACTOR_MACROS_SVH

`ifndef SYNTHESIS
`define SLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/sle_pkg.sv
`timescale 1ns / 1ps

package sle_pkg;

  localparam int unsigned MaxSegmentsDef    = 64;
  localparam int unsigned MaxOccurrencesDef = 4096;
  localparam int unsigned MaxBlocksDef      = 65536;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 112;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StNoTrid   = 3'd1,
    StNoCore   = 3'd2,
    StMismatch = 3'd3,
    StFull     = 3'd4,
    StTooMany  = 3'd5
  } status_e;

  typedef struct packed {
    logic [15:0] block_coreid;
    logic [15:0] block_trid;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [2:0]  status;
    logic [12:0] occurrence_count;
    logic [6:0]  unique_count;
    logic [15:0] repetition_id;
    logic        new_segment;
    logic [16:0] segment_length;
    logic [15:0] segment_offset;
    logic [15:0] segment_id;
    logic [5:0]  segment_index;
    logic [11:0] occurrence_index;
  } out_item_t;

  typedef struct packed {
    logic    load_in;
    logic    set_first;
    logic    open_seg;
    logic    bc_inc;
    logic    clear_run;
    logic    scan_clr;
    logic    scan_step;
    logic    emit_occ;
    logic    fresh;
    logic    emit_sum;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic drain;
    logic eos;
    logic bc_zero;
    logic trid_zero;
    logic core_zero;
    logic trid_new;
    logic bc_max;
    logic occ_full;
    logic uniq_full;
    logic scan_done;
    logic hit;
    logic len_match;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/sle_dp.sv
`timescale 1ns / 1ps
`include "segment_layout_extractor_macros.svh"

module sle_dp #(
  parameter int unsigned MAX_SEGMENTS    = sle_pkg::MaxSegmentsDef,
  parameter int unsigned MAX_OCCURRENCES = sle_pkg::MaxOccurrencesDef,
  parameter int unsigned MAX_BLOCKS      = sle_pkg::MaxBlocksDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sle_pkg::cmd_t       cmd_i,
  output sle_pkg::sts_t       sts_o,
  input  sle_pkg::in_item_t   in_item_i,
  input  logic                in_eos_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sle_pkg::out_item_t  out_item_o,
  output logic                out_last_o
);

  localparam int unsigned SegIdxW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned UniqW   = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned OccW    = $clog2(MAX_OCCURRENCES + 1);
  localparam int unsigned BcW     = $clog2(MAX_BLOCKS + 1);

  logic [15:0] trid_q, core_q;
  logic        eos_q;

  logic [15:0]      first_q, first_d;
  logic [BcW-1:0]   bc_q, bc_d;
  logic [15:0]      label_q, label_d;
  logic [BcW-1:0]   start_q, start_d;
  logic [OccW-1:0]  occ_q, occ_d;
  logic [UniqW-1:0] uniq_q, uniq_d;
  logic             drain_q, drain_d;
  logic [UniqW-1:0] scan_q, scan_d;
  logic             rd_v_q, rd_v_d;
  logic             out_valid_q, out_valid_d;

  logic [15:0]        mem_label [MAX_SEGMENTS];
  logic [BcW-1:0]     mem_off   [MAX_SEGMENTS];
  logic [BcW-1:0]     mem_len   [MAX_SEGMENTS];
  logic [SegIdxW-1:0] rd_idx_q;
  logic [15:0]        rd_label_q;
  logic [BcW-1:0]     rd_off_q;
  logic [BcW-1:0]     rd_len_q;

  logic [BcW-1:0]     len;
  logic [SegIdxW-1:0] idx_sel;
  logic [BcW-1:0]     off_sel, len_sel;
  logic [31:0]        occ_ext, uniq_ext, idx_ext, off_ext, len_ext;
  logic               emit;

  sle_pkg::out_item_t out_d, out_q;
  logic               last_q;

  assign len  = bc_q - start_q;
  assign emit = cmd_i.emit_occ | cmd_i.emit_sum;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      trid_q <= in_item_i.block_trid;
      core_q <= in_item_i.block_coreid;
      eos_q  <= in_eos_i;
    end
  end

  always_comb begin
    first_d     = first_q;
    bc_d        = bc_q;
    label_d     = label_q;
    start_d     = start_q;
    occ_d       = occ_q;
    uniq_d      = uniq_q;
    drain_d     = drain_q;
    scan_d      = scan_q;
    rd_v_d      = cmd_i.scan_step;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
    if (cmd_i.set_first) begin
      first_d = trid_q;
    end
    if (cmd_i.open_seg) begin
      label_d = core_q;
      start_d = bc_q;
    end
    if (cmd_i.bc_inc) begin
      bc_d = bc_q + BcW'(1);
    end
    if (cmd_i.scan_clr) begin
      scan_d = '0;
    end else if (cmd_i.scan_step) begin
      scan_d = scan_q + UniqW'(1);
    end
    if (cmd_i.emit_occ) begin
      occ_d = occ_q + OccW'(1);
      if (cmd_i.fresh) begin
        uniq_d = uniq_q + UniqW'(1);
      end
    end
    if (cmd_i.emit_sum) begin
      drain_d = 1'b1;
    end
    if (cmd_i.clear_run) begin
      first_d = '0;
      bc_d    = '0;
      label_d = '0;
      start_d = '0;
      occ_d   = '0;
      uniq_d  = '0;
      drain_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= '0;
      bc_q        <= '0;
      label_q     <= '0;
      start_q     <= '0;
      occ_q       <= '0;
      uniq_q      <= '0;
      drain_q     <= 1'b0;
      scan_q      <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      first_q     <= first_d;
      bc_q        <= bc_d;
      label_q     <= label_d;
      start_q     <= start_d;
      occ_q       <= occ_d;
      uniq_q      <= uniq_d;
      drain_q     <= drain_d;
      scan_q      <= scan_d;
      rd_v_q      <= rd_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Unique segment table: one write port for inserts, one registered read port for the scan.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_occ && cmd_i.fresh) begin
      mem_label[uniq_q[SegIdxW-1:0]] <= label_q;
      mem_off[uniq_q[SegIdxW-1:0]]   <= start_q;
      mem_len[uniq_q[SegIdxW-1:0]]   <= len;
    end
    if (cmd_i.scan_step) begin
      rd_idx_q   <= scan_q[SegIdxW-1:0];
      rd_label_q <= mem_label[scan_q[SegIdxW-1:0]];
      rd_off_q   <= mem_off[scan_q[SegIdxW-1:0]];
      rd_len_q   <= mem_len[scan_q[SegIdxW-1:0]];
    end
  end

  assign idx_sel  = cmd_i.fresh ? uniq_q[SegIdxW-1:0] : rd_idx_q;
  assign off_sel  = cmd_i.fresh ? start_q : rd_off_q;
  assign len_sel  = cmd_i.fresh ? len : rd_len_q;
  assign occ_ext  = 32'(occ_q);
  assign uniq_ext = 32'(uniq_q);
  assign idx_ext  = 32'(idx_sel);
  assign off_ext  = 32'(off_sel);
  assign len_ext  = 32'(len_sel);

  always_comb begin
    out_d = '0;
    if (cmd_i.emit_sum) begin
      out_d.repetition_id    = first_q;
      out_d.unique_count     = uniq_ext[6:0];
      out_d.occurrence_count = occ_ext[12:0];
      out_d.status           = cmd_i.status;
    end else begin
      out_d.occurrence_index = occ_ext[11:0];
      out_d.segment_index    = idx_ext[5:0];
      out_d.segment_id       = label_q;
      out_d.segment_offset   = off_ext[15:0];
      out_d.segment_length   = len_ext[16:0];
      out_d.new_segment      = cmd_i.fresh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q  <= out_d;
      last_q <= cmd_i.emit_sum;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_last_o  = last_q;

  assign sts_o.drain     = drain_q;
  assign sts_o.eos       = eos_q;
  assign sts_o.bc_zero   = (bc_q == '0);
  assign sts_o.trid_zero = (trid_q == '0);
  assign sts_o.core_zero = (core_q == '0);
  assign sts_o.trid_new  = (trid_q != '0) && (trid_q != first_q);
  assign sts_o.bc_max    = (bc_q >= BcW'(MAX_BLOCKS));
  assign sts_o.occ_full  = (occ_q >= OccW'(MAX_OCCURRENCES));
  assign sts_o.uniq_full = (uniq_q >= UniqW'(MAX_SEGMENTS));
  assign sts_o.scan_done = (scan_q >= uniq_q);
  assign sts_o.hit       = rd_v_q && (rd_label_q == label_q);
  assign sts_o.len_match = (rd_len_q == len);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  `SLE_ASSERT_IMP(a_single_emit, clk_i, rst_ni, cmd_i.emit_occ, !cmd_i.emit_sum, "two results in one cycle")
  `SLE_ASSERT_IMP(a_emit_free, clk_i, rst_ni, emit, !out_valid_q || out_ready_i, "result overwrites a waiting one")
  `SLE_ASSERT_NXT(a_insert_count, clk_i, rst_ni, cmd_i.emit_occ && cmd_i.fresh, uniq_q == $past(uniq_q) + UniqW'(1), "insert did not advance the unique count")
  `SLE_ASSERT_NXT(a_sum_drain, clk_i, rst_ni, cmd_i.emit_sum && !cmd_i.clear_run, drain_q, "summary without drain phase")

endmodule

>>> rtl/sle_ctrl.sv
`timescale 1ns / 1ps

module sle_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sle_pkg::sts_t sts_i,
  output sle_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_POST   = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_SEARCH = 4'd4;
  localparam logic [3:0] S_FOUND  = 4'd5;
  localparam logic [3:0] S_MISS   = 4'd6;
  localparam logic [3:0] S_RET    = 4'd7;
  localparam logic [3:0] S_SUM    = 4'd8;

  localparam logic [1:0] K_CORE = 2'd0;
  localparam logic [1:0] K_TRID = 2'd1;
  localparam logic [1:0] K_EOS  = 2'd2;

  logic [3:0]       state_q, state_d;
  logic [1:0]       kind_q, kind_d;
  sle_pkg::status_e st_q, st_d;

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    st_d       = st_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.status = st_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.drain) begin
          cmd_o.clear_run = sts_i.eos;
          state_d = S_IDLE;
        end else if (sts_i.bc_zero) begin
          if (sts_i.trid_zero) begin
            st_d = sle_pkg::StNoTrid;
            state_d = S_SUM;
          end else if (sts_i.core_zero) begin
            cmd_o.set_first = 1'b1;
            st_d = sle_pkg::StNoCore;
            state_d = S_SUM;
          end else begin
            cmd_o.set_first = 1'b1;
            cmd_o.open_seg  = 1'b1;
            state_d = S_POST;
          end
        end else if (sts_i.trid_new) begin
          kind_d = K_TRID;
          state_d = S_CHECK;
        end else if (sts_i.bc_max) begin
          st_d = sle_pkg::StTooMany;
          state_d = S_SUM;
        end else if (!sts_i.core_zero) begin
          kind_d = K_CORE;
          state_d = S_CHECK;
        end else begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        cmd_o.bc_inc = 1'b1;
        if (sts_i.eos) begin
          kind_d = K_EOS;
          state_d = S_CHECK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CHECK: begin
        if (sts_i.occ_full) begin
          st_d = sle_pkg::StFull;
          state_d = S_RET;
        end else begin
          cmd_o.scan_clr = 1'b1;
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts_i.hit) begin
          state_d = S_FOUND;
        end else if (sts_i.scan_done) begin
          state_d = S_MISS;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_FOUND: begin
        if (!sts_i.len_match) begin
          st_d = sle_pkg::StMismatch;
          state_d = S_RET;
        end else if (sts_i.out_free) begin
          cmd_o.emit_occ = 1'b1;
          st_d = sle_pkg::StOk;
          state_d = S_RET;
        end
      end
      S_MISS: begin
        if (sts_i.uniq_full) begin
          st_d = sle_pkg::StFull;
          state_d = S_RET;
        end else if (sts_i.out_free) begin
          cmd_o.emit_occ = 1'b1;
          cmd_o.fresh    = 1'b1;
          st_d = sle_pkg::StOk;
          state_d = S_RET;
        end
      end
      S_RET: begin
        if (kind_q == K_CORE && st_q == sle_pkg::StOk) begin
          cmd_o.open_seg = 1'b1;
          state_d = S_POST;
        end else begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sum  = 1'b1;
          cmd_o.clear_run = sts_i.eos;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= K_CORE;
      st_q    <= sle_pkg::StOk;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      st_q    <= st_d;
    end
  end

endmodule

>>> rtl/segment_layout_extractor.sv
`timescale 1ns / 1ps

// Segment layout extractor: takes one request per block (repetition label, segment label,
// end of sequence in tlast) and returns one result per closed segment occurrence plus one
// summary result, marked by tlast, that ends the repetition. Each closed occurrence adds
// a linear search of the unique segment table through its single registered read port,
// one entry per cycle. A block is taken only when the previous one is fully processed;
// a result waiting in the output register does not hold up the input until the next
// result is due.
module segment_layout_extractor #(
  parameter int unsigned MAX_SEGMENTS    = sle_pkg::MaxSegmentsDef,
  parameter int unsigned MAX_OCCURRENCES = sle_pkg::MaxOccurrencesDef,
  parameter int unsigned MAX_BLOCKS      = sle_pkg::MaxBlocksDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // block_trid[15:0], block_coreid[31:16]
  input  logic [sle_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // occurrence_index[11:0], segment_index[17:12], segment_id[33:18],
  // segment_offset[49:34], segment_length[66:50], new_segment[67],
  // repetition_id[83:68], unique_count[90:84], occurrence_count[103:91],
  // status[106:104], zero fill[111:107]
  output logic [sle_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tlast
);

  sle_pkg::cmd_t      cmd;
  sle_pkg::sts_t      sts;
  sle_pkg::in_item_t  in_item;
  sle_pkg::out_item_t out_item;

  assign in_item      = s_axis_tdata;
  assign m_axis_tdata = out_item;

  sle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sle_dp #(
    .MAX_SEGMENTS    (MAX_SEGMENTS),
    .MAX_OCCURRENCES (MAX_OCCURRENCES),
    .MAX_BLOCKS      (MAX_BLOCKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item),
    .in_eos_i    (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item),
    .out_last_o  (m_axis_tlast)
  );

endmodule
